// ===== hw/rtl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mexp_pkg;

  // Default datapath width and fixed field width of the item ports
  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_W       = 32;

  // Register file decode
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PUB_EXP  = 2'd1;
  localparam logic [IDX_W-1:0] REG_PRIV_EXP = 2'd2;

  // Register reset values
  localparam int MODULUS_RST  = 3233;
  localparam int PUB_EXP_RST  = 17;
  localparam int PRIV_EXP_RST = 2753;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } mexp_state_t;

  // Operand selection when a modular multiply is started
  typedef enum logic {
    MM_MUL,
    MM_SQR
  } mm_op_t;

  typedef struct packed {
    logic   load;       // capture item and operands, start base reduction
    logic   mm_start;   // start a modular multiply
    mm_op_t mm_op;      // operands of the started multiply
    logic   mm_step;    // one add-and-double step
    logic   base_wr;    // power <= multiplier accumulator
    logic   res_wr;     // running result <= multiplier accumulator
    logic   res_one;    // running result <= 1
    logic   exp_shift;  // exponent >>= 1
    logic   out_load;   // output register <= final result
  } mexp_cmd_t;

  typedef struct packed {
    logic mod_small;    // modulus below two
    logic exp_zero;
    logic exp_lsb;
    logic mm_done;      // multiplier operand exhausted
  } mexp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mexp_regs.sv =====
// APB-style configuration registers: modulus and the two exponents.
// Depends on mexp_pkg.
`default_nettype none

module mexp_regs
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [IDX_W+((WORD_BITS > 32) ? 3 : 2)-1:0] paddr,
  input  wire  [((WORD_BITS > 32) ? 64 : 32)-1:0]     pwdata,
  output logic [((WORD_BITS > 32) ? 64 : 32)-1:0]     prdata,
  output logic                pready,
  output logic [WORD_BITS-1:0] modulus,
  output logic [WORD_BITS-1:0] pub_exp,
  output logic [WORD_BITS-1:0] priv_exp
);

  localparam int DATA_W     = (WORD_BITS > 32) ? 64 : 32;
  localparam int ADDR_SHIFT = (WORD_BITS > 32) ? 3 : 2;
  localparam int ADDR_W     = IDX_W + ADDR_SHIFT;

  logic [WORD_BITS-1:0] modulus_r, modulus_nxt;
  logic [WORD_BITS-1:0] pub_exp_r, pub_exp_nxt;
  logic [WORD_BITS-1:0] priv_exp_r, priv_exp_nxt;
  logic [IDX_W-1:0]     idx;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wdata;

  assign idx    = paddr[ADDR_W-1:ADDR_SHIFT];
  assign wr_en  = psel & penable & pwrite;
  assign wdata  = pwdata[WORD_BITS-1:0];
  assign pready = 1'b1;

  always_comb begin
    modulus_nxt  = modulus_r;
    pub_exp_nxt  = pub_exp_r;
    priv_exp_nxt = priv_exp_r;
    if (wr_en) begin
      unique case (idx)
        REG_MODULUS:  modulus_nxt  = wdata;
        REG_PUB_EXP:  pub_exp_nxt  = wdata;
        REG_PRIV_EXP: priv_exp_nxt = wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WORD_BITS'(MODULUS_RST);
      pub_exp_r  <= WORD_BITS'(PUB_EXP_RST);
      priv_exp_r <= WORD_BITS'(PRIV_EXP_RST);
    end else begin
      modulus_r  <= modulus_nxt;
      pub_exp_r  <= pub_exp_nxt;
      priv_exp_r <= priv_exp_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODULUS:  prdata = DATA_W'(modulus_r);
      REG_PUB_EXP:  prdata = DATA_W'(pub_exp_r);
      REG_PRIV_EXP: prdata = DATA_W'(priv_exp_r);
      default:      prdata = '0;
    endcase
  end

  assign modulus  = modulus_r;
  assign pub_exp  = pub_exp_r;
  assign priv_exp = priv_exp_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_dp.sv =====
// Datapath: operand registers and a bit-serial modular multiplier
// (one add-and-double per cycle), plus the output register. Depends on mexp_pkg.
`default_nettype none

module mexp_dp
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire                  clk,
  input  mexp_cmd_t            cmd,
  output mexp_sts_t            sts,
  input  wire                  in_mode,
  input  wire  [FIELD_W-1:0]   in_base_value,
  input  wire  [WORD_BITS-1:0] modulus,
  input  wire  [WORD_BITS-1:0] pub_exp,
  input  wire  [WORD_BITS-1:0] priv_exp,
  output logic [FIELD_W-1:0]   out_result_value
);

  logic [WORD_BITS-1:0] m_r, m_nxt;
  logic [WORD_BITS-1:0] exp_r, exp_nxt;
  logic [WORD_BITS-1:0] base_r, base_nxt;     // current power
  logic [WORD_BITS-1:0] res_r, res_nxt;       // running result
  logic [WORD_BITS-1:0] acc_r, acc_nxt;       // multiplier accumulator
  logic [WORD_BITS-1:0] a_r, a_nxt;           // multiplicand, doubled each step
  logic [WORD_BITS-1:0] b_r, b_nxt;           // multiplier, shifted out LSB first
  logic [WORD_BITS-1:0] result_r, result_nxt;

  logic [WORD_BITS:0]   acc_sum, a_dbl;
  logic [WORD_BITS-1:0] acc_mod, a_mod;

  // Both operands are below m, so one conditional subtract reduces the sum
  assign acc_sum = {1'b0, acc_r} + {1'b0, a_r};
  assign a_dbl   = {a_r, 1'b0};
  assign acc_mod = (acc_sum >= {1'b0, m_r}) ? WORD_BITS'(acc_sum - {1'b0, m_r})
                                            : acc_sum[WORD_BITS-1:0];
  assign a_mod   = (a_dbl >= {1'b0, m_r}) ? WORD_BITS'(a_dbl - {1'b0, m_r})
                                          : a_dbl[WORD_BITS-1:0];

  always_comb begin
    m_nxt      = m_r;
    exp_nxt    = exp_r;
    base_nxt   = base_r;
    res_nxt    = res_r;
    acc_nxt    = acc_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    result_nxt = result_r;

    if (cmd.base_wr)   base_nxt = acc_r;
    if (cmd.res_wr)    res_nxt  = acc_r;
    if (cmd.res_one)   res_nxt  = WORD_BITS'(1);
    if (cmd.exp_shift) exp_nxt  = exp_r >> 1;

    // base mod m is formed as base * 1 mod m on the same multiplier
    if (cmd.load) begin
      m_nxt   = modulus;
      exp_nxt = in_mode ? priv_exp : pub_exp;
      acc_nxt = '0;
      a_nxt   = WORD_BITS'(1);
      b_nxt   = WORD_BITS'(in_base_value);
    end else if (cmd.mm_start) begin
      acc_nxt = '0;
      a_nxt   = base_r;
      b_nxt   = (cmd.mm_op == MM_MUL) ? res_r : base_r;
    end else if (cmd.mm_step) begin
      if (b_r[0]) acc_nxt = acc_mod;
      a_nxt = a_mod;
      b_nxt = b_r >> 1;
    end

    if (cmd.out_load) result_nxt = sts.mod_small ? '0 : res_r;
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    exp_r    <= exp_nxt;
    base_r   <= base_nxt;
    res_r    <= res_nxt;
    acc_r    <= acc_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    result_r <= result_nxt;
  end

  assign sts.mod_small = (m_r < WORD_BITS'(2));
  assign sts.exp_zero  = (exp_r == '0);
  assign sts.exp_lsb   = exp_r[0];
  assign sts.mm_done   = (b_r == '0);

  assign out_result_value = FIELD_W'(result_r);

endmodule

`default_nettype wire

// ===== hw/rtl/mexp_ctrl.sv =====
// Sequencer for square-and-multiply: walks reduce / multiply / square steps
// and owns both handshakes. Depends on mexp_pkg.
`default_nettype none

module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire       out_stall,
  input  mexp_sts_t sts,
  output mexp_cmd_t cmd
);

  mexp_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_REDUCE;
      ST_REDUCE: begin
        if (sts.mod_small)    state_nxt = ST_FINISH;
        else if (sts.mm_done) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.exp_zero)     state_nxt = ST_FINISH;
        else if (sts.exp_lsb) state_nxt = ST_MUL;
        else                  state_nxt = ST_SQR;
      end
      ST_MUL:    if (sts.mm_done) state_nxt = ST_SQR;
      ST_SQR:    if (sts.mm_done) state_nxt = ST_CHECK;
      ST_FINISH: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_REDUCE: begin
        if (!sts.mod_small) begin
          if (sts.mm_done) begin
            cmd.base_wr = 1'b1;
            cmd.res_one = 1'b1;
          end else begin
            cmd.mm_step = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (!sts.exp_zero) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = sts.exp_lsb ? MM_MUL : MM_SQR;
        end
      end
      ST_MUL: begin
        if (sts.mm_done) begin
          cmd.res_wr   = 1'b1;
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_SQR;
        end else begin
          cmd.mm_step = 1'b1;
        end
      end
      ST_SQR: begin
        if (sts.mm_done) begin
          cmd.base_wr   = 1'b1;
          cmd.exp_shift = 1'b1;
        end else begin
          cmd.mm_step = 1'b1;
        end
      end
      ST_FINISH: cmd.out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten before transfer");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_REDUCE))
    else $error("accepted item not started");

  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.base_wr || cmd.res_wr) |-> sts.mm_done)
    else $error("multiplier result taken before completion");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result valid raised outside finish");

endmodule

`default_nettype wire

// ===== hw/rtl/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation block: base^exp mod N.
// Depends on mexp_pkg, mexp_regs, mexp_ctrl, mexp_dp.
`default_nettype none

//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, in_mode, in_base_value   | sink
//  out     | out_valid, out_stall, out_result_value       | source
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata | APB slave
//
//  Item time grows with W = WORD_BITS and with the position of the top set
//  exponent bit; it is set by the bit-serial modular multiplier, one
//  add-and-double per cycle, shared by base reduction, multiply and square.
//  Reset (synchronous, rst_n low) restores N = 3233, e = 17, d = 2753.
//  One item at a time; the next transfer is taken while a result still
//  waits in the output register, and a finished item holds until it drains.

module modular_exponentiation_unit
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // item input
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_mode,
  input  wire  [FIELD_W-1:0]   in_base_value,
  // result output
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [FIELD_W-1:0]   out_result_value,
  // configuration
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [IDX_W+((WORD_BITS > 32) ? 3 : 2)-1:0] paddr,
  input  wire  [((WORD_BITS > 32) ? 64 : 32)-1:0]     pwdata,
  output logic [((WORD_BITS > 32) ? 64 : 32)-1:0]     prdata,
  output logic                 pready
);

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] pub_exp;
  logic [WORD_BITS-1:0] priv_exp;
  mexp_cmd_t            cmd;
  mexp_sts_t            sts;

  // Register file: modulus at index 0, public exponent 1, private exponent 2
  mexp_regs #(
    .WORD_BITS (WORD_BITS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .modulus  (modulus),
    .pub_exp  (pub_exp),
    .priv_exp (priv_exp)
  );

  // Sequencer: reduce base, then per exponent bit an optional multiply
  // into the running result followed by a square of the power
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Operands are snapshotted at the input transfer
  mexp_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_base_value    (in_base_value),
    .modulus          (modulus),
    .pub_exp          (pub_exp),
    .priv_exp         (priv_exp),
    .out_result_value (out_result_value)
  );

endmodule

`default_nettype wire

// ===== bench/modular_exponentiation_unit_test.sv =====
// Self-checking testbench for modular_exponentiation_unit (base^exp mod N).
// Depends on mexp_pkg and the RTL of the block; the scoreboard class below
// predicts every result from its own copy of the three key registers.
`timescale 1ns / 100ps

import mexp_pkg::*;

localparam logic MODE_ENCRYPT = 1'b0;
localparam logic MODE_DECRYPT = 1'b1;

class mexp_scoreboard;
  logic [FIELD_W-1:0] mod_n;
  logic [FIELD_W-1:0] exp_e;
  logic [FIELD_W-1:0] exp_d;
  logic [FIELD_W-1:0] results_due[$];
  int unsigned        n_errors;

  function new();
    mod_n    = MODULUS_RST;
    exp_e    = PUB_EXP_RST;
    exp_d    = PRIV_EXP_RST;
    n_errors = 0;
  endfunction

  function void write_reg(logic [IDX_W-1:0] idx, logic [FIELD_W-1:0] value);
    case (idx)
      REG_MODULUS:  mod_n = value;
      REG_PUB_EXP:  exp_e = value;
      REG_PRIV_EXP: exp_d = value;
      default: ;
    endcase
  endfunction

  function logic [FIELD_W-1:0] read_reg(logic [IDX_W-1:0] idx);
    case (idx)
      REG_MODULUS:  return mod_n;
      REG_PUB_EXP:  return exp_e;
      default:      return exp_d;
    endcase
  endfunction

  // right-to-left square and multiply; operands stay below 2^32 so the
  // 64-bit products never wrap
  function logic [FIELD_W-1:0] raise_mod(logic [FIELD_W-1:0] base,
                                         logic [FIELD_W-1:0] expo,
                                         logic [FIELD_W-1:0] m);
    logic [63:0]        acc;
    logic [63:0]        pwr;
    logic [63:0]        m64;
    logic [FIELD_W-1:0] bits;
    if (m < 2) return '0;
    m64  = 64'(m);
    acc  = 64'd1;
    pwr  = 64'(base) % m64;
    bits = expo;
    while (bits != 0) begin
      if (bits[0]) acc = (acc * pwr) % m64;
      pwr  = (pwr * pwr) % m64;
      bits = bits >> 1;
    end
    return acc[FIELD_W-1:0];
  endfunction

  function void note_input(logic mode, logic [FIELD_W-1:0] base);
    results_due.push_back(raise_mod(base, (mode == MODE_DECRYPT) ? exp_d : exp_e, mod_n));
  endfunction

  function void check_result(logic [FIELD_W-1:0] got);
    logic [FIELD_W-1:0] want;
    if (results_due.size() == 0) begin
      $error("result_value: no result pending, got %0d", got);
      n_errors++;
      return;
    end
    want = results_due.pop_front();
    if (got !== want) begin
      $error("result_value: expected %0d, got %0d", want, got);
      n_errors++;
    end
  endfunction

  function int pending();
    return results_due.size();
  endfunction
endclass

module modular_exponentiation_unit_test;

  // Unused register slot: a write there must change nothing
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

  localparam int RANDOM_ITEMS = 1900;
  localparam int SMALL_PHASE  = 48;     // items per phase with short exponents
  localparam int WIDE_PHASE   = 10;     // items per phase with full 32-bit exponents
  localparam int HOLD_AT      = 300;    // accepted transfers before the long hold-off
  localparam int HOLD_CYCLES  = 8000;   // several items' worth, so the block backs up
  localparam int TAIL_CYCLES  = 100;
  // Well above the worst run (clock period 20 ns) even with every gap and stall
  // at its longest.
  localparam int TIMEOUT_NS   = 250_000_000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic [FIELD_W-1:0] in_base_value;
  logic               out_valid;
  logic               out_stall;
  logic [FIELD_W-1:0] out_result_value;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [IDX_W+1:0]   paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  mexp_scoreboard sb;
  int unsigned    accepted_items = 0;
  string          reg_label [3] = '{"modulus", "public_exponent", "private_exponent"};

  modular_exponentiation_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs or a handshake never completes
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: every transfer is checked against the oldest prediction.
  // Values sampled here are the ones present at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_result_value);
  end

  // Receiver stall pattern: runs of free flow, short stalls, a few long ones,
  // and one long hold-off once traffic is well under way so that the block
  // fills up and has to stall its input.
  initial begin : result_sink
    int unsigned r;
    int unsigned len;
    bit          hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && accepted_items >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        len = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 12);
        end else if (r < 62) begin
          out_stall <= 1'b0;
          len = $urandom_range(100, 400);
        end else if (r < 94) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(20, 150);
        end
      end
      repeat (len) @(posedge clk);
    end
  end

  // One transfer on the input channel. Called at a rising edge; valid is only
  // dropped when a gap is asked for, so back-to-back items keep it high.
  task automatic send_item(input logic mode, input logic [FIELD_W-1:0] base,
                           input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_base_value <= base;
    do @(posedge clk); while (in_stall);
    sb.note_input(mode, base);
    accepted_items++;
  endtask

  // Stop offering items and wait until every prediction has been matched
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Setup then access phase; psel stays up so transfers can run back to back
  task automatic apb_transfer(input logic wr, input logic [IDX_W-1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  // Register write followed by a read-back of the same register, except for the unused slot
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_transfer(1'b1, idx, value, rd);
    sb.write_reg(idx, value);
    if (idx != REG_NONE) begin
      apb_transfer(1'b0, idx, '0, rd);
      if (rd !== sb.read_reg(idx))
        $error("%s: expected %0d, got %0d", reg_label[idx], sb.read_reg(idx), rd);
      if (rd !== sb.read_reg(idx)) sb.n_errors++;
    end
  endtask

  task automatic cfg_done();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_exponent(bit wide);
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 5);
    if (!wide) return $urandom & ((32'd1 << k) - 32'd1);
    if (r < 15) return 32'hFFFF_FFFF;
    if (r < 25) return '0;
    if (r < 60) return $urandom | 32'h8000_0000;
    return $urandom;
  endfunction

  initial begin : stimulus
    int unsigned        sent;
    int unsigned        phase;
    int unsigned        n_items;
    int unsigned        r;
    int unsigned        gap;
    bit                 wide;
    bit                 no_gaps;
    logic [FIELD_W-1:0] m;
    logic [FIELD_W-1:0] base;

    sb = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_mode       <= MODE_ENCRYPT;
    in_base_value <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- Directed part ---
    // Reset key (N = 3233, e = 17, d = 2753): textbook pair, bases at and
    // around the modulus, and the widest base.
    send_item(MODE_ENCRYPT, 32'd0, 0);
    send_item(MODE_ENCRYPT, 32'd1, 0);
    send_item(MODE_ENCRYPT, 32'd65, 0);
    send_item(MODE_DECRYPT, 32'd2790, 0);
    send_item(MODE_ENCRYPT, 32'd3232, 0);
    send_item(MODE_DECRYPT, 32'd3233, 0);
    send_item(MODE_ENCRYPT, 32'd3234, 0);
    send_item(MODE_DECRYPT, 32'hFFFF_FFFF, 0);
    wait_idle();

    // Widest modulus, zero public exponent, all-ones private exponent
    cfg_write(REG_MODULUS,  32'hFFFF_FFFF);
    cfg_write(REG_PUB_EXP,  32'd0);
    cfg_write(REG_PRIV_EXP, 32'hFFFF_FFFF);
    cfg_done();
    send_item(MODE_ENCRYPT, 32'hFFFF_FFFF, 0);   // base reduces to zero, 0^0 = 1
    send_item(MODE_DECRYPT, 32'd0, 0);
    send_item(MODE_DECRYPT, 32'd1, 0);
    send_item(MODE_DECRYPT, 32'hFFFF_FFFE, 0);
    send_item(MODE_DECRYPT, 32'h8000_0000, 0);
    send_item(MODE_ENCRYPT, 32'h1234_5678, 0);
    wait_idle();

    // Degenerate moduli zero and one: every result is zero
    cfg_write(REG_MODULUS, 32'd0);
    cfg_write(REG_PUB_EXP, 32'd5);
    cfg_done();
    send_item(MODE_ENCRYPT, 32'd7, 0);
    send_item(MODE_DECRYPT, 32'hFFFF_FFFF, 0);
    wait_idle();
    cfg_write(REG_MODULUS, 32'd1);
    cfg_done();
    send_item(MODE_ENCRYPT, 32'd0, 0);
    send_item(MODE_DECRYPT, 32'd5, 0);
    wait_idle();

    // Smallest valid modulus; a write to the unused slot must not alias
    cfg_write(REG_MODULUS,  32'd2);
    cfg_write(REG_PUB_EXP,  32'd1);
    cfg_write(REG_PRIV_EXP, 32'h8000_0000);
    cfg_write(REG_NONE,     32'd0);
    cfg_done();
    send_item(MODE_ENCRYPT, 32'hFFFF_FFFF, 0);
    send_item(MODE_DECRYPT, 32'd3, 0);
    send_item(MODE_ENCRYPT, 32'd2, 0);
    wait_idle();

    // --- Random part ---
    // Phases of one key each. Cost per item grows with the exponent length,
    // so most phases use exponents of a few bits and every eighth phase
    // uses full-width exponents with few items.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wide    = (phase % 8 == 7);
      n_items = wide ? WIDE_PHASE : SMALL_PHASE;
      no_gaps = ($urandom_range(0, 3) == 0);

      r = $urandom_range(0, 99);
      if (r < 65)      m = $urandom;
      else if (r < 78) m = $urandom_range(2, 65535);
      else if (r < 86) m = 32'hFFFF_FFFF;
      else if (r < 91) m = $urandom_range(2, 3);
      else if (r < 97) m = 32'h8000_0000 | $urandom_range(0, 15);
      else             m = $urandom_range(0, 1);

      cfg_write(REG_MODULUS,  m);
      cfg_write(REG_PUB_EXP,  pick_exponent(wide));
      cfg_write(REG_PRIV_EXP, pick_exponent(wide));
      if ($urandom_range(0, 9) == 0) cfg_write(REG_NONE, $urandom);
      cfg_done();

      repeat (n_items) begin
        // bases at and just above the modulus exercise the pre-reduction
        r = $urandom_range(0, 99);
        if (r < 70)      base = $urandom;
        else if (r < 78) base = m - 32'd1;
        else if (r < 84) base = m;
        else if (r < 90) base = $urandom_range(0, 3);
        else if (r < 95) base = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else             base = m + $urandom_range(1, 5);

        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) gap = 0;
        else if (r < 85)       gap = $urandom_range(1, 3);
        else if (r < 97)       gap = $urandom_range(4, 20);
        else                   gap = $urandom_range(50, 800);

        send_item(logic'($urandom_range(0, 1)), base, gap);
        sent++;
      end
      wait_idle();
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
